// ===== hdl/prm_pkg.sv =====
// Shared types and constants for the packet rule matcher.
// Depends on nothing; used by prm_port_match and packet_rule_match_top.
package prm_pkg;

  localparam int unsigned AddrW     = 32;
  localparam int unsigned PortW     = 16;
  localparam int unsigned RangeW    = 2 * PortW;
  localparam int unsigned ProtoW    = 8;
  localparam int unsigned HostBitsW = 6;
  localparam int unsigned CountW    = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgAddrW  = 6;

  // Register index, taken from paddr[5:3] (registers sit on 8-byte strides).
  typedef enum logic [2:0] {
    RegProtoMask   = 3'd0,
    RegSrcPrefix   = 3'd1,
    RegSrcHostBits = 3'd2,
    RegDstPrefix   = 3'd3,
    RegDstHostBits = 3'd4,
    RegSrcRanges   = 3'd5,
    RegDstRanges   = 3'd6,
    RegRangeCounts = 3'd7
  } reg_idx_e;

  // Compare an address against a prefix, ignoring the low host bits.
  // A host count of 32 or more matches any address.
  function automatic logic addr_hit(input logic [AddrW-1:0]     addr,
                                    input logic [AddrW-1:0]     pat,
                                    input logic [HostBitsW-1:0] host);
    logic [AddrW-1:0] mask;
    mask = {AddrW{1'b1}} << host[4:0];
    if (host[5]) begin
      return 1'b1;
    end
    return ((addr ^ pat) & mask) == '0;
  endfunction

endpackage

// ===== hdl/prm_port_match.sv =====
// Port range check: the port falls in one of the enabled inclusive ranges, or none is enabled.
// Depends on prm_pkg for widths.
module prm_port_match #(
  parameter int unsigned RANGES_PER_PORT = 2
) (
  input  logic [prm_pkg::PortW-1:0]                    port_i,
  input  logic [RANGES_PER_PORT*prm_pkg::RangeW-1:0]   ranges_i,
  input  logic [prm_pkg::CountW-1:0]                   count_i,
  output logic                                         hit_o
);

  localparam logic [prm_pkg::CountW-1:0] MaxCount = prm_pkg::CountW'(RANGES_PER_PORT);

  logic [prm_pkg::CountW-1:0] count_sat;
  logic [RANGES_PER_PORT-1:0] range_hit;

  // Saturate the range count to the number of stored ranges.
  assign count_sat = (count_i > MaxCount) ? MaxCount : count_i;

  for (genvar k = 0; k < RANGES_PER_PORT; k++) begin : g_range
    logic [prm_pkg::PortW-1:0] lo;
    logic [prm_pkg::PortW-1:0] hi;
    assign hi = ranges_i[k*prm_pkg::RangeW +: prm_pkg::PortW];
    assign lo = ranges_i[k*prm_pkg::RangeW + prm_pkg::PortW +: prm_pkg::PortW];
    assign range_hit[k] = (prm_pkg::CountW'(k) < count_sat) &&
                          (port_i >= lo) && (port_i <= hi);
  end

  assign hit_o = (count_i == '0) || (|range_hit);

endmodule

// ===== hdl/packet_rule_match_top.sv =====
// A result is strobed on done_o/matched_o from the result register; an item taken
// with start_i passes through the input register and the match logic first.
// Throughput: one item per cycle; busy_o stays low, the input register and the
// result register form a two-stage pipe with no feedback.
// Results are strobed for one cycle; the receiver cannot stall the block.
// Reset (rst_ni low, asynchronous): both pipe stages empty, rule registers return to
// match all but protocol class 0 (protocol mask all ones, host counts 32, range counts 0).
module packet_rule_match_top #(
  parameter int unsigned RANGES_PER_PORT = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [prm_pkg::CfgAddrW-1:0]      paddr,
  input  logic [prm_pkg::CfgDataW-1:0]      pwdata,
  output logic [prm_pkg::CfgDataW-1:0]      prdata,
  output logic                              pready,
  // Command side
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [prm_pkg::ProtoW-1:0]        protocol_class_i,
  input  logic [prm_pkg::AddrW-1:0]         src_addr_i,
  input  logic [prm_pkg::AddrW-1:0]         dst_addr_i,
  input  logic [prm_pkg::PortW-1:0]         src_port_i,
  input  logic [prm_pkg::PortW-1:0]         dst_port_i,
  // Result side
  output logic                              done_o,
  output logic                              matched_o
);

  localparam int unsigned RangesW = RANGES_PER_PORT * prm_pkg::RangeW;

  // ---------------------------------------------------------------------------
  // Rule registers
  // ---------------------------------------------------------------------------
  logic [prm_pkg::ProtoW-1:0]    proto_mask_q;
  logic [prm_pkg::AddrW-1:0]     src_prefix_q;
  logic [prm_pkg::HostBitsW-1:0] src_host_q;
  logic [prm_pkg::AddrW-1:0]     dst_prefix_q;
  logic [prm_pkg::HostBitsW-1:0] dst_host_q;
  logic [RangesW-1:0]            src_ranges_q;
  logic [RangesW-1:0]            dst_ranges_q;
  logic [2*prm_pkg::CountW-1:0]  range_counts_q;

  logic              cfg_wr;
  prm_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  // Registers sit on 8-byte strides; the low three address bits are ignored.
  assign cfg_idx = prm_pkg::reg_idx_e'(paddr[5:3]);

  // Write the addressed register; only the stored range words are kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_mask_q   <= '1;
      src_prefix_q   <= '0;
      src_host_q     <= prm_pkg::HostBitsW'(prm_pkg::AddrW);
      dst_prefix_q   <= '0;
      dst_host_q     <= prm_pkg::HostBitsW'(prm_pkg::AddrW);
      src_ranges_q   <= '0;
      dst_ranges_q   <= '0;
      range_counts_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        prm_pkg::RegProtoMask:   proto_mask_q   <= pwdata[prm_pkg::ProtoW-1:0];
        prm_pkg::RegSrcPrefix:   src_prefix_q   <= pwdata[prm_pkg::AddrW-1:0];
        prm_pkg::RegSrcHostBits: src_host_q     <= pwdata[prm_pkg::HostBitsW-1:0];
        prm_pkg::RegDstPrefix:   dst_prefix_q   <= pwdata[prm_pkg::AddrW-1:0];
        prm_pkg::RegDstHostBits: dst_host_q     <= pwdata[prm_pkg::HostBitsW-1:0];
        prm_pkg::RegSrcRanges:   src_ranges_q   <= pwdata[RangesW-1:0];
        prm_pkg::RegDstRanges:   dst_ranges_q   <= pwdata[RangesW-1:0];
        prm_pkg::RegRangeCounts: range_counts_q <= pwdata[2*prm_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero-extended to the bus width.
  always_comb begin
    case (cfg_idx)
      prm_pkg::RegProtoMask:   prdata = prm_pkg::CfgDataW'(proto_mask_q);
      prm_pkg::RegSrcPrefix:   prdata = prm_pkg::CfgDataW'(src_prefix_q);
      prm_pkg::RegSrcHostBits: prdata = prm_pkg::CfgDataW'(src_host_q);
      prm_pkg::RegDstPrefix:   prdata = prm_pkg::CfgDataW'(dst_prefix_q);
      prm_pkg::RegDstHostBits: prdata = prm_pkg::CfgDataW'(dst_host_q);
      prm_pkg::RegSrcRanges:   prdata = prm_pkg::CfgDataW'(src_ranges_q);
      prm_pkg::RegDstRanges:   prdata = prm_pkg::CfgDataW'(dst_ranges_q);
      prm_pkg::RegRangeCounts: prdata = prm_pkg::CfgDataW'(range_counts_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic                       in_vld_q;
  logic [prm_pkg::ProtoW-1:0] proto_q;
  logic [prm_pkg::AddrW-1:0]  src_addr_q;
  logic [prm_pkg::AddrW-1:0]  dst_addr_q;
  logic [prm_pkg::PortW-1:0]  src_port_q;
  logic [prm_pkg::PortW-1:0]  dst_port_q;
  logic                       accept;

  // Never stall: every cycle can take a new item.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  // Payload needs no reset; capture only on an accepted item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      proto_q    <= protocol_class_i;
      src_addr_q <= src_addr_i;
      dst_addr_q <= dst_addr_i;
      src_port_q <= src_port_i;
      dst_port_q <= dst_port_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Match logic: all five tests side by side, then AND them together
  // ---------------------------------------------------------------------------
  logic proto_hit;
  logic src_addr_hit;
  logic dst_addr_hit;
  logic src_port_hit;
  logic dst_port_hit;
  logic match_d;

  assign proto_hit    = |(proto_q & proto_mask_q);
  assign src_addr_hit = prm_pkg::addr_hit(src_addr_q, src_prefix_q, src_host_q);
  assign dst_addr_hit = prm_pkg::addr_hit(dst_addr_q, dst_prefix_q, dst_host_q);

  prm_port_match #(
    .RANGES_PER_PORT(RANGES_PER_PORT)
  ) u_src_port (
    .port_i  (src_port_q),
    .ranges_i(src_ranges_q),
    .count_i (range_counts_q[prm_pkg::CountW-1:0]),
    .hit_o   (src_port_hit)
  );

  prm_port_match #(
    .RANGES_PER_PORT(RANGES_PER_PORT)
  ) u_dst_port (
    .port_i  (dst_port_q),
    .ranges_i(dst_ranges_q),
    .count_i (range_counts_q[2*prm_pkg::CountW-1:prm_pkg::CountW]),
    .hit_o   (dst_port_hit)
  );

  assign match_d = proto_hit && src_addr_hit && dst_addr_hit &&
                   src_port_hit && dst_port_hit;

  // ---------------------------------------------------------------------------
  // Stage 2: result register, strobed for one cycle
  // ---------------------------------------------------------------------------
  logic done_q;
  logic matched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      matched_q <= match_d;
    end
  end

  assign done_o    = done_q;
  assign matched_o = matched_q;

endmodule
